FILE: design/stream_find_replace_assert.svh
// Assertion macros shared by the stream find-and-replace RTL.
`ifndef STREAM_FIND_REPLACE_ASSERT_SVH
`define STREAM_FIND_REPLACE_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds at every clock edge out of reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next.
`define SFR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define SFR_ASSERT(lbl, prop, msg)
`define SFR_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: design/sfr_pkg.sv
// Types, sizes and helpers of the stream find-and-replace block.
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // Longest pattern and replacement
  localparam int MAX_PAT = 8;
  localparam int MAX_REP = 8;

  // Longest list of result beats one input beat can cause (at least the end marker)
  localparam int MAX_LIST = (MAX_PAT > MAX_REP) ? MAX_PAT : MAX_REP;
  // Output queue holds one pending list plus room for the next
  localparam int QDEPTH   = 2 * MAX_LIST;

  localparam int PCW = $clog2(MAX_PAT + 1);
  localparam int RCW = (MAX_REP > 0) ? $clog2(MAX_REP + 1) : 1;
  localparam int LCW = $clog2(MAX_LIST + 1);
  localparam int LIW = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_BYTES = 3'd0,
    REG_PAT_LEN   = 3'd1,
    REG_REP_BYTES = 3'd2,
    REG_REP_LEN   = 3'd3
  } cfg_reg_e;

  // One result beat
  typedef struct packed {
    logic [7:0] data;
    logic       dval;
    logic       last;
  } entry_t;

  typedef entry_t [MAX_LIST-1:0] list_t;

  // Window cell controls
  typedef struct packed {
    logic en;
    logic clear;
    logic shift;
  } win_ctl_t;

  // Queue cell controls
  typedef struct packed {
    logic           pop;
    logic           load;
    logic [QCW-1:0] base;
    logic [LCW-1:0] len;
  } que_ctl_t;

  // Byte pos of a 64-bit word, zero past the eighth
  function automatic logic [7:0] byte_at(input logic [63:0] word, input int unsigned pos);
    logic [7:0] b;
    b = 8'h00;
    if (pos < 8) begin
      b = word[8*pos +: 8];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: design/sfr_in_if.sv
// Input text channel: one text byte per beat.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

`default_nettype wire

FILE: design/sfr_out_if.sv
// Result channel: one output byte or end marker per beat.
`timescale 1ns / 1ps
`default_nettype none

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

`default_nettype wire

FILE: design/sfr_win_cell.sv
// Match window cell: holds one text byte and compares it with its pattern byte.
`timescale 1ns / 1ps
`default_nettype none

module sfr_win_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sfr_pkg::win_ctl_t ctl_i,
  input  wire logic            push_i,  // new byte lands in this cell
  input  wire logic [7:0]      new_i,
  input  wire logic [7:0]      pat_i,
  input  wire logic [7:0]      nbr_i,   // neighbor's byte after push
  output logic      [7:0]      wp_o,    // this cell's byte after push
  output logic                 eq_o
);

  logic [7:0] held_q, held_d;

  // Byte seen by this beat's compare
  assign wp_o = push_i ? new_i : held_q;
  assign eq_o = (wp_o == pat_i);

  // Clear, load the pushed byte, shift toward the oldest end, or keep
  always_comb begin
    held_d = held_q;
    if (ctl_i.clear) begin
      held_d = 8'h00;
    end else if (ctl_i.en) begin
      held_d = ctl_i.shift ? nbr_i : wp_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 8'h00;
    end else begin
      held_q <= held_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/sfr_que_cell.sv
// Output queue cell: holds one result beat, loads from the new list or its neighbor.
`timescale 1ns / 1ps
`default_nettype none

module sfr_que_cell (
  input  wire logic                     clk_i,
  input  wire sfr_pkg::que_ctl_t        ctl_i,
  input  wire logic [sfr_pkg::QCW-1:0]  idx_i,
  input  wire sfr_pkg::list_t           list_i,
  input  wire sfr_pkg::entry_t          nbr_i,
  output sfr_pkg::entry_t               ent_o
);

  sfr_pkg::entry_t         ent_q, ent_d;
  logic [sfr_pkg::QCW-1:0] rel;
  logic                    hit;

  // Position of this cell inside the appended list
  assign rel = idx_i - ctl_i.base;
  assign hit = ctl_i.load && (idx_i >= ctl_i.base) &&
               (rel < sfr_pkg::QCW'(ctl_i.len));

  always_comb begin
    ent_d = ent_q;
    if (hit) begin
      ent_d = list_i[rel[sfr_pkg::LIW-1:0]];
    end else if (ctl_i.pop) begin
      ent_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

`default_nettype wire

FILE: design/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
//
//   channel  dir  beat                               handshake
//   in_i     in   data_byte, end_of_text             valid/ready
//   out_o    out  out_byte, out_valid, out_last      valid/ready
//   cfg      in   cfg_idx_i, cfg_data_i              cfg_we_i, no wait
//
// Each accepted input beat queues 0 to 8 result beats.
// Result beats leave at one per cycle while out_o.ready is high, from a 16-entry
// queue (output register at entry 0). in_i.ready is high while the queue holds 8
// beats or fewer, so a replacement burst or end-of-text flush stalls input only
// once more than 8 beats wait.
// One byte in, one byte out sustains one beat per cycle while out_o.ready stays high.
// Reset: empty window and queue, pattern length 1, other registers zero; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

`include "stream_find_replace_assert.svh"

module stream_find_replace (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  sfr_in_if.sink                              in_i,
  sfr_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [sfr_pkg::CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int MP = sfr_pkg::MAX_PAT;
  localparam int ML = sfr_pkg::MAX_LIST;
  localparam int QD = sfr_pkg::QDEPTH;

  // Configuration registers
  logic [63:0] pat_q, rep_q;
  logic [3:0]  plen_q, rlen_q;
  logic        plen_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      rep_q  <= '0;
      plen_q <= 4'd1;
      rlen_q <= '0;
    end else if (cfg_we_i) begin
      case (sfr_pkg::cfg_reg_e'(cfg_idx_i))
        sfr_pkg::REG_PAT_BYTES: pat_q  <= cfg_data_i[63:0];
        sfr_pkg::REG_PAT_LEN:   plen_q <= cfg_data_i[3:0];
        sfr_pkg::REG_REP_BYTES: rep_q  <= cfg_data_i[63:0];
        sfr_pkg::REG_REP_LEN:   rlen_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign plen_wr = cfg_we_i && (sfr_pkg::cfg_reg_e'(cfg_idx_i) == sfr_pkg::REG_PAT_LEN);

  // Effective lengths: zero pattern acts as one, both capped
  logic [sfr_pkg::PCW-1:0] plen_eff;
  logic [sfr_pkg::RCW-1:0] rlen_eff;

  always_comb begin
    if (32'(plen_q) > MP) begin
      plen_eff = sfr_pkg::PCW'(MP);
    end else if (plen_q == 4'd0) begin
      plen_eff = sfr_pkg::PCW'(1);
    end else begin
      plen_eff = sfr_pkg::PCW'(plen_q);
    end
    if (32'(rlen_q) > sfr_pkg::MAX_REP) begin
      rlen_eff = sfr_pkg::RCW'(sfr_pkg::MAX_REP);
    end else begin
      rlen_eff = sfr_pkg::RCW'(rlen_q);
    end
  end

  // Handshake
  logic                    acc, pop;
  logic [sfr_pkg::QCW-1:0] count_q, count_d, base;

  assign in_i.ready = (count_q <= sfr_pkg::QCW'(ML));
  assign acc        = in_i.valid && in_i.ready;
  assign out_o.valid = (count_q != '0);
  assign pop        = out_o.valid && out_o.ready;

  // Window fill and match decision
  logic [sfr_pkg::PCW-1:0] fill_q, fill_d, cnt;
  logic [MP-1:0]           eq, used, push;
  logic [7:0]              wp [MP];
  logic                    full, sel_rep, eot;
  sfr_pkg::win_ctl_t       wctl;

  assign eot     = in_i.end_of_text;
  assign cnt     = fill_q + sfr_pkg::PCW'(1);
  assign full    = (cnt == plen_eff);
  assign sel_rep = full && ((eq | ~used) == '1);

  assign wctl.en    = acc;
  assign wctl.clear = plen_wr || (acc && (sel_rep || eot));
  assign wctl.shift = full;

  // Row of window cells, oldest byte in cell 0
  for (genvar i = 0; i < MP; i++) begin : g_win
    logic [7:0] nbr;
    assign used[i] = (32'(i) < 32'(plen_eff));
    assign push[i] = (32'(i) == 32'(fill_q));
    if (i == MP - 1) begin : g_end
      assign nbr = 8'h00;
    end else begin : g_mid
      assign nbr = wp[i+1];
    end
    sfr_win_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (wctl),
      .push_i (push[i]),
      .new_i  (in_i.data_byte),
      .pat_i  (sfr_pkg::byte_at(pat_q, i)),
      .nbr_i  (nbr),
      .wp_o   (wp[i]),
      .eq_o   (eq[i])
    );
  end

  always_comb begin
    fill_d = fill_q;
    if (plen_wr) begin
      fill_d = '0;
    end else if (acc) begin
      if (sel_rep || eot) begin
        fill_d = '0;
      end else if (full) begin
        fill_d = fill_q;
      end else begin
        fill_d = cnt;
      end
    end
  end

  // Result list of this beat
  logic [sfr_pkg::LCW-1:0] len_raw, len;
  logic                    marker;
  sfr_pkg::list_t          list;

  always_comb begin
    if (sel_rep) begin
      len_raw = sfr_pkg::LCW'(rlen_eff);
    end else if (eot) begin
      len_raw = sfr_pkg::LCW'(cnt);
    end else if (full) begin
      len_raw = sfr_pkg::LCW'(1);
    end else begin
      len_raw = '0;
    end
  end

  // Empty end of text gets one marker beat
  assign marker = eot && (len_raw == '0);
  assign len    = marker ? sfr_pkg::LCW'(1) : len_raw;

  for (genvar j = 0; j < ML; j++) begin : g_list
    logic [7:0] src;
    if (j < MP) begin : g_win_src
      assign src = sel_rep ? sfr_pkg::byte_at(rep_q, j) : wp[j];
    end else begin : g_rep_src
      assign src = sel_rep ? sfr_pkg::byte_at(rep_q, j) : 8'h00;
    end
    assign list[j].data = marker ? 8'h00 : src;
    assign list[j].dval = !marker;
    assign list[j].last = eot && (sfr_pkg::LCW'(j) == len - sfr_pkg::LCW'(1));
  end

  // Output queue: row of cells, head in cell 0
  sfr_pkg::que_ctl_t qctl;
  sfr_pkg::entry_t   ent [QD];

  assign base      = count_q - sfr_pkg::QCW'(pop);
  assign qctl.pop  = pop;
  assign qctl.load = acc;
  assign qctl.base = base;
  assign qctl.len  = len;

  for (genvar i = 0; i < QD; i++) begin : g_que
    sfr_pkg::entry_t nbr;
    if (i == QD - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    sfr_que_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (qctl),
      .idx_i  (sfr_pkg::QCW'(i)),
      .list_i (list),
      .nbr_i  (nbr),
      .ent_o  (ent[i])
    );
  end

  assign count_d = base + (acc ? sfr_pkg::QCW'(len) : '0);

  assign out_o.out_byte  = ent[0].data;
  assign out_o.out_valid = ent[0].dval;
  assign out_o.out_last  = ent[0].last;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
    end
  end

  // Checks
  `SFR_ASSERT(a_que_bound, count_q <= sfr_pkg::QCW'(QD), "output queue overflow")
  `SFR_ASSERT(a_fill_below_len, fill_q < plen_eff, "window held a full pattern between beats")
  `SFR_ASSERT_NEXT(a_eot_empties, acc && eot, fill_q == '0, "window not empty after end of text")
  `SFR_ASSERT(a_marker_last, !(out_o.valid && !out_o.out_valid) || out_o.out_last, "marker without last")
  `SFR_ASSERT_NEXT(a_pop_count, pop && !acc, count_q == $past(count_q) - sfr_pkg::QCW'(1), "queue count slip")

endmodule

`default_nettype wire
